### src/awt_pkg.sv
// Shared types, constants and widths for the ack window tracker.
package awt_pkg;

   localparam int MAX_RANGES = 16;
   localparam int WORD_W     = 64;
   localparam int IDX_W      = $clog2(WORD_W);
   localparam int SHAMT_W    = IDX_W + 1;
   localparam int PN_W       = 62;
   localparam int RN_W       = 63;
   localparam int TIME_W     = 64;
   localparam int LEN_W      = 6;
   localparam int RC_W       = 5;
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);

   localparam logic MODE_RCPT   = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

   typedef enum logic [1:0] {
      KIND_RCPT,
      KIND_HDR,
      KIND_PAIR,
      KIND_NONE
   } kind_type;

   typedef enum logic [1:0] {
      SCAN_NOP,
      SCAN_LZC,
      SCAN_SHL,
      SCAN_ROL
   } scan_op_type;

   typedef struct packed {
      scan_op_type          op;
      logic                 invert;
      logic [SHAMT_W-1:0]   amount;
   } scan_cmd_type;

   typedef struct packed {
      logic                 mode;
      logic [PN_W-1:0]      pkt_num;
      logic [TIME_W-1:0]    rx_time;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic                 fast_ack;
      logic [PN_W-1:0]      largest_acked;
      logic [LEN_W-1:0]     first_range;
      logic [RC_W-1:0]      range_count;
      logic [LEN_W-1:0]     gap_len;
      logic [LEN_W-1:0]     range_len;
      logic [TIME_W-1:0]    newest_rx_time;
      logic                 last;
   } rsp_type;

endpackage

### src/awt_if.sv
// Valid/ready channel interfaces for requests, responses and the control register.
interface awt_req_if;
   logic              valid;
   logic              ready;
   awt_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface awt_rsp_if;
   logic              valid;
   logic              ready;
   awt_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface awt_csr_if;
   logic              valid;
   logic              ready;
   logic              data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### src/awt_scan_unit.sv
// Shared scan unit: leading-zero count, left shift or rotate, result registered.
module awt_scan_unit (
   input  logic                         clock,
   input  awt_pkg::scan_cmd_type        cmd,
   input  logic [awt_pkg::WORD_W-1:0]   operand,
   output logic [awt_pkg::WORD_W-1:0]   res,
   output logic [awt_pkg::SHAMT_W-1:0]  cnt
);
   import awt_pkg::*;

   logic [WORD_W-1:0]  res_ff;
   logic [SHAMT_W-1:0] cnt_ff;
   logic [WORD_W-1:0]  lzc_src;
   logic [SHAMT_W-1:0] lzc_val;
   logic [WORD_W-1:0]  shl_val;
   logic [WORD_W-1:0]  rol_val;
   logic [7:0]         byte_nz;
   logic [2:0]         byte_lz [8];

   function automatic logic [2:0] lz8(input logic [7:0] v);
      logic [2:0] z;
      z = 3'd0;
      for (int j = 0; j < 8; j++) begin
         if (v[j]) begin
            z = 3'(7 - j);
         end
      end
      return z;
   endfunction

   assign lzc_src = cmd.invert ? ~operand : operand;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         byte_nz[b] = |lzc_src[WORD_W-1-8*b -: 8];
         byte_lz[b] = lz8(lzc_src[WORD_W-1-8*b -: 8]);
      end
      lzc_val = SHAMT_W'(WORD_W);
      for (int b = 7; b >= 0; b--) begin
         if (byte_nz[b]) begin
            lzc_val = {1'b0, 3'(b), byte_lz[b]};
         end
      end
   end

   assign shl_val = cmd.amount[SHAMT_W-1] ? '0 : (operand << cmd.amount[IDX_W-1:0]);
   assign rol_val = (operand << cmd.amount[IDX_W-1:0])
                  | (operand >> (SHAMT_W'(WORD_W) - {1'b0, cmd.amount[IDX_W-1:0]}));

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         SCAN_LZC: cnt_ff <= lzc_val;
         SCAN_SHL: res_ff <= shl_val;
         SCAN_ROL: res_ff <= rol_val;
         default: ;
      endcase
   end

   assign res = res_ff;
   assign cnt = cnt_ff;

endmodule

### src/awt_ctrl.sv
// Window state, receipt update and report sequencer driving the scan unit.
module awt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fast_ack_enable,
   awt_req_if.sink                      req_ch,
   awt_rsp_if.source                    rsp_ch,
   output awt_pkg::scan_cmd_type        scan_cmd,
   output logic [awt_pkg::WORD_W-1:0]   scan_operand,
   input  logic [awt_pkg::WORD_W-1:0]   scan_res,
   input  logic [awt_pkg::SHAMT_W-1:0]  scan_cnt
);
   import awt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RCPT_OUT,
      S_NONE_OUT,
      S_ROT,
      S_FIRST_SH,
      S_TEST,
      S_GAP_SH,
      S_BLK_LZ,
      S_BLK_SH,
      S_HDR_OUT,
      S_PAIR_OUT
   } state_type;

   state_type          state_ff;
   logic [RN_W-1:0]    recv_next_ff;
   logic [WORD_W-1:0]  bitmap_ff;
   logic [TIME_W-1:0]  latest_ff;
   logic               fast_ff;
   logic [WORD_W-1:0]  rx_ff;
   logic [LEN_W-1:0]   first_ff;
   logic [LEN_W-1:0]   gap_ff;
   logic [LEN_W-1:0]   blk_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   done_ff;
   logic               pass_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [RN_W-1:0]    recv_next_in;
   logic [WORD_W-1:0]  bitmap_in;
   logic [TIME_W-1:0]  latest_in;
   logic               fast_in;
   rsp_type            rsp_in;
   logic               rsp_load;

   logic               accept;
   logic               slot_free;
   logic [WORD_W-1:0]  num_w;
   logic [WORD_W-1:0]  rn_w;
   logic               too_old;
   logic               at_or_above;
   logic               ahead;
   logic               long_jump;
   logic [IDX_W-1:0]   jump_len;
   logic [IDX_W-1:0]   offs;
   logic [WORD_W-1:0]  clr;
   logic [SHAMT_W-1:0] rot_amt;
   logic               cont;
   logic               pair_last;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // receipt window update
   always_comb begin
      num_w       = {2'b00, req_ch.data.pkt_num};
      rn_w        = {1'b0, recv_next_ff};
      too_old     = (num_w + 64'd64) < rn_w;
      at_or_above = num_w >= rn_w;
      ahead       = num_w > rn_w;
      long_jump   = num_w >= (rn_w + 64'd64);
      jump_len    = req_ch.data.pkt_num[IDX_W-1:0] - recv_next_ff[IDX_W-1:0];
      for (int i = 0; i < WORD_W; i++) begin
         offs   = IDX_W'(i) - recv_next_ff[IDX_W-1:0];
         clr[i] = offs < jump_len;
      end
      fast_in      = fast_ack_enable && ahead;
      recv_next_in = recv_next_ff;
      latest_in    = latest_ff;
      bitmap_in    = bitmap_ff;
      if (!too_old) begin
         if (at_or_above) begin
            recv_next_in = {1'b0, req_ch.data.pkt_num} + RN_W'(1);
            latest_in    = req_ch.data.rx_time;
         end
         if (long_jump) begin
            bitmap_in = '0;
         end else if (ahead) begin
            bitmap_in = bitmap_ff & ~clr;
         end
         bitmap_in[req_ch.data.pkt_num[IDX_W-1:0]] = 1'b1;
      end
   end

   assign rot_amt   = {1'b0, IDX_W'(0) - recv_next_ff[IDX_W-1:0]};
   assign cont      = pass_ff ? (done_ff != count_ff)
                              : ((scan_res != '0) && (count_ff != CNT_W'(MAX_RANGES)));
   assign pair_last = CNT_W'(done_ff + 1'b1) == count_ff;

   // scan unit commands
   always_comb begin
      scan_cmd     = '{op: SCAN_NOP, invert: 1'b0, amount: '0};
      scan_operand = rx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_ch.data.mode == MODE_REPORT && recv_next_ff != '0) begin
               scan_cmd     = '{op: SCAN_ROL, invert: 1'b0, amount: rot_amt};
               scan_operand = bitmap_ff;
            end
         end
         S_HDR_OUT: begin
            if (slot_free && count_ff != '0) begin
               scan_cmd     = '{op: SCAN_ROL, invert: 1'b0, amount: rot_amt};
               scan_operand = bitmap_ff;
            end
         end
         S_ROT: begin
            scan_cmd     = '{op: SCAN_LZC, invert: 1'b1, amount: '0};
            scan_operand = {scan_res[WORD_W-2:0], 1'b0};
         end
         S_TEST: begin
            if (cont) begin
               scan_cmd     = '{op: SCAN_LZC, invert: 1'b0, amount: '0};
               scan_operand = scan_res;
            end
         end
         S_BLK_LZ: begin
            scan_cmd     = '{op: SCAN_LZC, invert: 1'b1, amount: '0};
            scan_operand = scan_res;
         end
         S_FIRST_SH, S_GAP_SH, S_BLK_SH: begin
            scan_cmd = '{op: SCAN_SHL, invert: 1'b0, amount: scan_cnt};
         end
         default: ;
      endcase
   end

   // result assembly
   always_comb begin
      rsp_in   = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_RCPT_OUT: begin
            rsp_load        = slot_free;
            rsp_in.kind     = KIND_RCPT;
            rsp_in.fast_ack = fast_ff;
            rsp_in.last     = 1'b1;
         end
         S_NONE_OUT: begin
            rsp_load    = slot_free;
            rsp_in.kind = KIND_NONE;
            rsp_in.last = 1'b1;
         end
         S_HDR_OUT: begin
            rsp_load              = slot_free;
            rsp_in.kind           = KIND_HDR;
            rsp_in.largest_acked  = recv_next_ff[PN_W-1:0] - PN_W'(1);
            rsp_in.first_range    = first_ff;
            rsp_in.range_count    = RC_W'(count_ff);
            rsp_in.newest_rx_time = latest_ff;
            rsp_in.last           = count_ff == '0;
         end
         S_PAIR_OUT: begin
            rsp_load         = slot_free;
            rsp_in.kind      = KIND_PAIR;
            rsp_in.gap_len   = gap_ff;
            rsp_in.range_len = blk_ff;
            rsp_in.last      = pair_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         recv_next_ff <= '0;
         bitmap_ff    <= '0;
         latest_ff    <= '0;
         count_ff     <= '0;
         done_ff      <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_ch.data.mode == MODE_RCPT) begin
                     recv_next_ff <= recv_next_in;
                     bitmap_ff    <= bitmap_in;
                     latest_ff    <= latest_in;
                     fast_ff      <= fast_in;
                     state_ff     <= S_RCPT_OUT;
                  end else if (recv_next_ff == '0) begin
                     state_ff <= S_NONE_OUT;
                  end else begin
                     pass_ff  <= 1'b0;
                     count_ff <= '0;
                     state_ff <= S_ROT;
                  end
               end
            end
            S_RCPT_OUT, S_NONE_OUT: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            S_ROT: begin
               rx_ff    <= {scan_res[WORD_W-2:0], 1'b0};
               state_ff <= S_FIRST_SH;
            end
            S_FIRST_SH: begin
               first_ff <= scan_cnt[LEN_W-1:0];
               state_ff <= S_TEST;
            end
            S_TEST: begin
               if (cont) begin
                  rx_ff    <= scan_res;
                  state_ff <= S_GAP_SH;
               end else begin
                  state_ff <= S_HDR_OUT;
               end
            end
            S_GAP_SH: begin
               gap_ff   <= scan_cnt[LEN_W-1:0];
               state_ff <= S_BLK_LZ;
            end
            S_BLK_LZ: begin
               rx_ff    <= scan_res;
               state_ff <= S_BLK_SH;
            end
            S_BLK_SH: begin
               blk_ff <= scan_cnt[LEN_W-1:0];
               if (pass_ff) begin
                  state_ff <= S_PAIR_OUT;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_TEST;
               end
            end
            S_HDR_OUT: begin
               if (slot_free) begin
                  if (count_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     pass_ff  <= 1'b1;
                     done_ff  <= '0;
                     state_ff <= S_ROT;
                  end
               end
            end
            S_PAIR_OUT: begin
               if (slot_free) begin
                  done_ff  <= done_ff + 1'b1;
                  state_ff <= pair_last ? S_IDLE : S_TEST;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready = state_ff == S_IDLE;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

### src/ack_window_tracker.sv
// Top level of the ack window tracker: control register, sequencer and scan unit.
//
// Channels: req_ch takes items (mode 0 receipt with pkt_num and rx_time,
// mode 1 report request); rsp_ch returns result items; csr_ch writes the
// fast_ack_enable bit, is always ready and should only be written while idle.
// A receipt yields one item (kind 0).
// A report with nothing received yields one kind 3 item.
// Otherwise a report yields a header (kind 1) and then up to MAX_RANGES
// gap/range pairs (kind 2); last marks the final item. The bitmap is scanned
// twice by the shared leading-zero/shift unit, first to count ranges and then
// to emit them.
// One item is worked on at a time; req_ch.ready is high only when idle, which
// includes the time a finished item waits in the output register.
// A stalled receiver holds the current item in the output register and the
// sequencer waits until that register frees up.
// Reset clears the window (recv_next, bitmap, newest time), empties the output
// register and sets fast_ack_enable.
module ack_window_tracker (
   input  logic      clock,
   input  logic      reset,
   awt_req_if.sink   req_ch,
   awt_rsp_if.source rsp_ch,
   awt_csr_if.sink   csr_ch
);
   import awt_pkg::*;

   logic                fast_ack_enable_ff;
   scan_cmd_type        scan_cmd;
   logic [WORD_W-1:0]   scan_operand;
   logic [WORD_W-1:0]   scan_res;
   logic [SHAMT_W-1:0]  scan_cnt;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ack_enable_ff <= 1'b1;
      end else if (csr_ch.valid && csr_ch.ready) begin
         fast_ack_enable_ff <= csr_ch.data;
      end
   end

   awt_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .fast_ack_enable (fast_ack_enable_ff),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .scan_cmd        (scan_cmd),
      .scan_operand    (scan_operand),
      .scan_res        (scan_res),
      .scan_cnt        (scan_cnt)
   );

   awt_scan_unit u_scan (
      .clock   (clock),
      .cmd     (scan_cmd),
      .operand (scan_operand),
      .res     (scan_res),
      .cnt     (scan_cnt)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("accepted a second item while busy");

   a_hdr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.kind == KIND_HDR |->
         (rsp_ch.data.last == (rsp_ch.data.range_count == '0)) &&
         ({1'b0, rsp_ch.data.range_count} <= (RC_W+1)'(MAX_RANGES)))
      else $error("header count or last flag inconsistent");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.data.kind == KIND_NONE || rsp_ch.data.kind == KIND_RCPT)
         |-> rsp_ch.data.last)
      else $error("single-item result without last");

   a_pair_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.kind == KIND_PAIR |->
         rsp_ch.data.gap_len != '0 && rsp_ch.data.range_len != '0)
      else $error("empty gap or range in pair");
`endif

endmodule
